### rtl/bmat_pkg.sv
// ----------------------------------------------------------------------------
// bmat_pkg
// Types and constants shared by the banked memory address translator.
// ----------------------------------------------------------------------------
`default_nettype none

package bmat_pkg;

  localparam int ADDR_W     = 16;
  localparam int OFF_W      = 18;
  localparam int BANK_SHIFT = 15;

  typedef enum logic {
    OP_ZERO_PAGE = 1'b0,
    OP_INDEXED   = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_RAM = 2'd0,
    KIND_MAP = 2'd1,
    KIND_ROM = 2'd2
  } kind_t;

  // configuration register indexes
  typedef enum logic {
    CFG_ZERO_PAGE = 1'b0,
    CFG_BANK      = 1'b1
  } cfg_index_t;

  typedef struct packed {
    opcode_t            opcode;
    logic [ADDR_W-1:0]  cpu_address;
    logic [7:0]         extension_byte;
  } in_beat_t;

  typedef struct packed {
    kind_t              target_kind;
    logic [OFF_W-1:0]   physical_offset;
    logic [OFF_W-1:0]   extension_offset;
  } out_beat_t;

  // zero page register limits
  localparam logic [7:0] ZP_SYS_LIMIT  = 8'h20;
  localparam logic [7:0] ZP_HIGH_LIMIT = 8'h9F;
  localparam logic [7:0] EXT_PAGE_LO   = 8'h18;
  localparam logic [7:0] EXT_PAGE_HI   = 8'h1F;

  // extension byte codes
  localparam logic [7:0] EXT_SYS_WINDOW = 8'h8F;
  localparam logic [7:0] EXT_BANK_LO    = 8'h80;
  localparam logic [7:0] EXT_BANK_HI    = 8'h8E;
  localparam logic [7:0] EXT_CPU_MAP    = 8'hFF;

  // address boundaries
  localparam logic [ADDR_W-1:0] VEC_LO      = 16'hFFD0;
  localparam logic [ADDR_W-1:0] VEC_HI      = 16'hFFEF;
  localparam logic [ADDR_W-1:0] LOW_MASK    = 16'h7FFF;
  localparam logic [ADDR_W-1:0] ZP_END      = 16'h0100;
  localparam logic [ADDR_W-1:0] WINDOW_BASE = 16'h2000;
  localparam logic [ADDR_W-1:0] WINDOW_END  = 16'hA000;
  localparam logic [ADDR_W-1:0] IO_BASE     = 16'hC000;
  localparam logic [ADDR_W-1:0] IO_END      = 16'hD000;
  localparam logic [ADDR_W-1:0] ROM_BASE    = 16'hF000;
  localparam logic [ADDR_W-1:0] HIGH_SUB    = 16'h8000;
  localparam logic [ADDR_W-1:0] EXT_XOR     = 16'h0C00;

  // bank substituted when the top bank is requested
  localparam int FOLD_BANK = 2;

endpackage

`default_nettype wire

### rtl/bmat_bank_map.sv
// ----------------------------------------------------------------------------
// bmat_bank_map
// Reduces a requested bank number modulo the bank count, top bank folded to 2.
// ----------------------------------------------------------------------------
`default_nettype none

module bmat_bank_map #(
  parameter int RAM_BANKS = 8
) (
  input  wire logic [7:0]                   bank_req,
  output logic      [$clog2(RAM_BANKS)-1:0] bank_sel
);
  import bmat_pkg::*;

  localparam int BW = $clog2(RAM_BANKS);

  logic [BW-1:0] mod_tab [256];
  logic [BW-1:0] bank_mod;

  // constant residue table
  for (genvar i = 0; i < 256; i++) begin : g_tab
    assign mod_tab[i] = BW'(i % RAM_BANKS);
  end

  assign bank_mod = mod_tab[bank_req];
  assign bank_sel = (bank_mod == BW'(RAM_BANKS - 1)) ? BW'(FOLD_BANK) : bank_mod;

endmodule

`default_nettype wire

### rtl/bmat_wrap_offset.sv
// ----------------------------------------------------------------------------
// bmat_wrap_offset
// bank * 32K + base - sub, wrapped once into the RAM size.
// ----------------------------------------------------------------------------
`default_nettype none

module bmat_wrap_offset #(
  parameter int RAM_BANKS = 8
) (
  input  wire logic [$clog2(RAM_BANKS)-1:0] bank,
  input  wire logic [bmat_pkg::ADDR_W-1:0]  base,
  input  wire logic [bmat_pkg::ADDR_W-1:0]  sub,
  output logic      [bmat_pkg::OFF_W-1:0]   offset
);
  import bmat_pkg::*;

  localparam int RAM_SIZE = RAM_BANKS * 32768;
  localparam int VW       = $clog2(RAM_SIZE) + 2;

  logic [VW-1:0] sum;
  logic [VW-1:0] wrapped;

  // sum lies in (-32K, RAM_SIZE + 32K), so one correction is enough
  assign sum = (VW'(bank) << BANK_SHIFT) + VW'(base) - VW'(sub);

  always_comb begin
    priority if (sum[VW-1]) begin
      wrapped = sum + VW'(RAM_SIZE);
    end else if (sum >= VW'(RAM_SIZE)) begin
      wrapped = sum - VW'(RAM_SIZE);
    end else begin
      wrapped = sum;
    end
  end

  assign offset = wrapped[OFF_W-1:0];

endmodule

`default_nettype wire

### rtl/bmat_translate.sv
// ----------------------------------------------------------------------------
// bmat_translate
// Single-pass decode of one access into target kind and RAM offsets.
// ----------------------------------------------------------------------------
`default_nettype none

module bmat_translate #(
  parameter int RAM_BANKS = 8
) (
  input  wire bmat_pkg::in_beat_t          item,
  input  wire logic [7:0]                  zero_page,
  input  wire logic [7:0]                  bank_reg,
  input  wire logic [bmat_pkg::ADDR_W-1:0] page_cur,
  output logic      [bmat_pkg::ADDR_W-1:0] page_nxt,
  output bmat_pkg::out_beat_t              result
);
  import bmat_pkg::*;

  localparam int BW = $clog2(RAM_BANKS);

  logic [BW-1:0]     bank_sys;
  logic [BW-1:0]     bank_reg_sel;
  logic [BW-1:0]     bank_ext_sel;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] zp_page;
  logic [7:0]        ext;
  kind_t             kind;
  logic [BW-1:0]     bank;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] sub;
  logic [OFF_W-1:0]  phys_off;
  logic [OFF_W-1:0]  ext_off;

  assign bank_sys = BW'(RAM_BANKS - 1);
  assign addr     = item.cpu_address;
  assign ext      = item.extension_byte;
  assign zp_page  = {zero_page, addr[7:0]};

  bmat_bank_map #(.RAM_BANKS(RAM_BANKS)) u_map_reg (
    .bank_req (bank_reg),
    .bank_sel (bank_reg_sel)
  );

  bmat_bank_map #(.RAM_BANKS(RAM_BANKS)) u_map_ext (
    .bank_req (ext),
    .bank_sel (bank_ext_sel)
  );

  always_comb begin
    kind     = KIND_RAM;
    bank     = bank_sys;
    base     = addr;
    sub      = '0;
    page_nxt = page_cur;
    if (item.opcode == OP_ZERO_PAGE) begin
      page_nxt = zp_page;
      base     = zp_page;
      priority if (zero_page > ZP_HIGH_LIMIT) begin
        sub = HIGH_SUB;
      end else if (zero_page >= ZP_SYS_LIMIT) begin
        bank = bank_reg_sel;
        sub  = WINDOW_BASE;
      end else begin
        // low pages sit in the system bank as they are
        sub = '0;
      end
    end else if (zero_page >= EXT_PAGE_LO && zero_page <= EXT_PAGE_HI) begin
      priority if (ext == EXT_SYS_WINDOW) begin
        priority if (addr >= VEC_LO && addr <= VEC_HI) begin
          base = addr & LOW_MASK;
        end else if (addr < WINDOW_BASE) begin
          sub = WINDOW_BASE;
        end else if (addr >= WINDOW_END) begin
          sub = HIGH_SUB;
        end else begin
          // absolute offset, addr - 2000 never wraps
          bank = '0;
          sub  = WINDOW_BASE;
        end
      end else if (ext >= EXT_BANK_LO && ext <= EXT_BANK_HI) begin
        if (addr < ZP_END) begin
          base = zp_page;
        end else begin
          bank = bank_ext_sel;
        end
      end else if (ext == EXT_CPU_MAP) begin
        priority if (addr < WINDOW_BASE) begin
          sub = WINDOW_BASE;
        end else if (addr < WINDOW_END) begin
          bank = bank_reg_sel;
          sub  = WINDOW_BASE;
        end else if (addr < IO_BASE) begin
          sub = HIGH_SUB;
        end else if (addr < IO_END) begin
          kind = KIND_MAP;
        end else if (addr < ROM_BASE) begin
          sub = HIGH_SUB;
        end else begin
          kind = KIND_ROM;
        end
      end else if (addr < ZP_END) begin
        base = zp_page;
      end else begin
        kind = KIND_MAP;
      end
    end else begin
      kind = KIND_MAP;
    end
  end

  bmat_wrap_offset #(.RAM_BANKS(RAM_BANKS)) u_phys (
    .bank   (bank),
    .base   (base),
    .sub    (sub),
    .offset (phys_off)
  );

  // extension lookup address follows the updated page address
  bmat_wrap_offset #(.RAM_BANKS(RAM_BANKS)) u_ext (
    .bank   (bank_sys),
    .base   (page_nxt ^ EXT_XOR),
    .sub    (ADDR_W'(0)),
    .offset (ext_off)
  );

  assign result.target_kind      = kind;
  assign result.physical_offset  = (kind == KIND_RAM) ? phys_off : '0;
  assign result.extension_offset = ext_off;

endmodule

`default_nettype wire

### rtl/banked_memory_address_translator_core.sv
// ----------------------------------------------------------------------------
// banked_memory_address_translator_core
// Top level: input register, translation logic and output register.
// ----------------------------------------------------------------------------
// Translates CPU accesses of an 8-bit banked machine into RAM offsets. One
// beat goes in and one result beat comes out for each access; a beat passes
// through the input register, then the output register, and a new
// beat is taken every cycle while the result side keeps up. A zero page
// access (opcode 0) forms the page address from the zero page register and
// the low address byte and remembers it; an indexed access (opcode 1) with
// the zero page register at 18-1F is steered by the extension byte to RAM,
// the normal map or ROM, else to the normal map. The extension_offset field
// always gives the system-bank offset of the remembered page address xor
// 0C00, which is where the caller fetches the next extension byte.
// Configuration writes are only expected while no beat is in flight.
`default_nettype none

module banked_memory_address_translator_core #(
  parameter int RAM_BANKS = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input channel
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire bmat_pkg::in_beat_t     in_data,
  // result channel
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output bmat_pkg::out_beat_t         out_data,
  // configuration write port
  input  wire logic                   cfg_we,
  input  wire bmat_pkg::cfg_index_t   cfg_index,
  input  wire logic [7:0]             cfg_data
);
  import bmat_pkg::*;

  // configuration registers
  logic [7:0]        zp_r;
  logic [7:0]        bank_r;

  // remembered page address
  logic [ADDR_W-1:0] page_r;
  logic [ADDR_W-1:0] page_nxt;

  // input stage
  logic              s1_valid_r;
  logic              s1_valid_nxt;
  in_beat_t          s1_r;

  // output stage
  logic              out_valid_r;
  logic              out_valid_nxt;
  out_beat_t         out_r;
  out_beat_t         result;

  logic              advance;
  logic              move;
  logic              in_take;

  // the input stage hands on whenever the output register is free or drains
  assign advance  = !out_valid_r || !out_stall;
  assign move     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !advance);
  assign out_valid_nxt = move || (out_valid_r && out_stall);

  bmat_translate #(.RAM_BANKS(RAM_BANKS)) u_translate (
    .item      (s1_r),
    .zero_page (zp_r),
    .bank_reg  (bank_r),
    .page_cur  (page_r),
    .page_nxt  (page_nxt),
    .result    (result)
  );

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zp_r        <= 8'h00;
      bank_r      <= 8'hFF;
      page_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      // page address moves on with the beat that leaves the input stage
      if (move) begin
        page_r <= page_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ZERO_PAGE: zp_r   <= cfg_data;
          CFG_BANK:      bank_r <= cfg_data;
          default:       ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_r <= in_data;
    end
    if (move) begin
      out_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

### sim/bmat_translation_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmat_translation_checker
// Watches both channels of the translator, predicts each result beat from
// its own copy of the registers and page address, and counts mismatches.
// ----------------------------------------------------------------------------
module bmat_translation_checker #(
  parameter int RAM_BANKS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  bmat_pkg::in_beat_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  bmat_pkg::out_beat_t out_data,
  input  logic                cfg_we,
  input  bmat_pkg::cfg_index_t cfg_index,
  input  logic [7:0]          cfg_data,
  output int                  fail_count,
  output int                  pending,
  output int                  beats_taken,
  output int                  results_seen
);
  import bmat_pkg::*;

  localparam int unsigned BANK_BYTES = 1 << BANK_SHIFT;
  localparam int unsigned RAM_BYTES  = RAM_BANKS * BANK_BYTES;
  localparam int          MAX_PRINTS = 40;

  logic [7:0]  zp_reg    = 8'h00;
  logic [7:0]  bank_reg  = 8'hFF;
  logic [15:0] page_addr = 16'h0000;
  out_beat_t   expected_translations[$];
  out_beat_t   want;

  initial begin
    fail_count   = 0;
    pending      = 0;
    beats_taken  = 0;
    results_seen = 0;
  end

  // offsets wrap round the whole ram
  function automatic int unsigned ram_off(input int unsigned bank, input int unsigned base,
                                          input int unsigned sub);
    return (bank * BANK_BYTES + base + 2 * RAM_BYTES - sub) % RAM_BYTES;
  endfunction

  function automatic int unsigned sys_off(input int unsigned base, input int unsigned sub);
    return ram_off(RAM_BANKS - 1, base, sub);
  endfunction

  // the top bank is never selectable, it folds onto bank 2
  function automatic int unsigned sel_off(input int unsigned bank, input int unsigned base,
                                          input int unsigned sub);
    int unsigned b;
    b = bank % RAM_BANKS;
    if (b == RAM_BANKS - 1) b = FOLD_BANK;
    return ram_off(b, base, sub);
  endfunction

  function automatic out_beat_t translate_access(input in_beat_t beat);
    out_beat_t   r;
    int unsigned addr;
    int unsigned zp;
    int unsigned phys;
    int unsigned ext_off;
    kind_t       kind;
    addr = beat.cpu_address;
    zp   = zp_reg;
    phys = 0;
    kind = KIND_RAM;
    if (beat.opcode == OP_ZERO_PAGE) begin
      page_addr = {zp_reg, beat.cpu_address[7:0]};
      if (zp_reg < ZP_SYS_LIMIT) phys = sys_off(page_addr, 0);
      else if (zp_reg > ZP_HIGH_LIMIT) phys = sys_off(page_addr, HIGH_SUB);
      else phys = sel_off(bank_reg, page_addr, WINDOW_BASE);
    end else if (zp_reg >= EXT_PAGE_LO && zp_reg <= EXT_PAGE_HI) begin
      if (beat.extension_byte == EXT_SYS_WINDOW) begin
        if (addr >= VEC_LO && addr <= VEC_HI) phys = sys_off(addr & LOW_MASK, 0);
        else if (addr < WINDOW_BASE) phys = sys_off(addr, WINDOW_BASE);
        else if (addr >= WINDOW_END) phys = sys_off(addr, HIGH_SUB);
        else phys = addr - WINDOW_BASE;
      end else if (beat.extension_byte >= EXT_BANK_LO && beat.extension_byte <= EXT_BANK_HI) begin
        if (addr < ZP_END) phys = sys_off(zp * 256 + addr, 0);
        else phys = sel_off(beat.extension_byte, addr, 0);
      end else if (beat.extension_byte == EXT_CPU_MAP) begin
        if (addr < WINDOW_BASE) phys = sys_off(addr, WINDOW_BASE);
        else if (addr < WINDOW_END) phys = sel_off(bank_reg, addr, WINDOW_BASE);
        else if (addr < IO_BASE) phys = sys_off(addr, HIGH_SUB);
        else if (addr < IO_END) kind = KIND_MAP;
        else if (addr < ROM_BASE) phys = sys_off(addr, HIGH_SUB);
        else kind = KIND_ROM;
      end else if (addr < ZP_END) begin
        phys = sys_off(zp * 256 + addr, 0);
      end else begin
        kind = KIND_MAP;
      end
    end else begin
      kind = KIND_MAP;
    end
    if (kind != KIND_RAM) phys = 0;
    ext_off = sys_off(page_addr ^ EXT_XOR, 0);
    r.target_kind      = kind;
    r.physical_offset  = phys[OFF_W-1:0];
    r.extension_offset = ext_off[OFF_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned exp_val);
    fail_count++;
    if (fail_count <= MAX_PRINTS)
      $display("mismatch at %0t ns: %s got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      zp_reg    = 8'h00;
      bank_reg  = 8'hFF;
      page_addr = 16'h0000;
      expected_translations.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ZERO_PAGE: zp_reg   = cfg_data;
          CFG_BANK:      bank_reg = cfg_data;
          default: ;
        endcase
      end
      // compare before queueing, so a beat leaving and one entering on the
      // same edge line up correctly
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_translations.size() == 0) begin
          report_mismatch("result beat with nothing outstanding", out_data, 0);
        end else begin
          want = expected_translations.pop_front();
          if (out_data.target_kind !== want.target_kind)
            report_mismatch("target_kind", out_data.target_kind, want.target_kind);
          if (out_data.physical_offset !== want.physical_offset)
            report_mismatch("physical_offset", out_data.physical_offset,
                            want.physical_offset);
          if (out_data.extension_offset !== want.extension_offset)
            report_mismatch("extension_offset", out_data.extension_offset,
                            want.extension_offset);
        end
      end
      if (in_valid && !in_stall) begin
        beats_taken++;
        expected_translations.push_back(translate_access(in_data));
      end
    end
    pending = expected_translations.size();
  end

endmodule

### sim/banked_memory_address_translator_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banked_memory_address_translator_core_test
// Drives directed corner accesses and then phases of random access
// sequences under changing register settings, with bursty input and a
// patterned result stall; the checker predicts and compares every beat.
// ----------------------------------------------------------------------------
module banked_memory_address_translator_core_test;
  import bmat_pkg::*;

  localparam int RAM_BANKS       = 8;
  localparam int HALF_PERIOD     = 10;
  localparam int RESET_CYCLES    = 8;
  // two register stages in the block, so a handful of cycles is plenty
  localparam int SETTLE_CYCLES   = 4;
  localparam int RANDOM_PHASES   = 12;
  localparam int BEATS_PER_PHASE = 112;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_beat_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_beat_t   out_data;
  logic        cfg_we    = 1'b0;
  cfg_index_t  cfg_index = CFG_ZERO_PAGE;
  logic [7:0]  cfg_data  = 8'h00;

  int fail_count;
  int pending;
  int beats_taken;
  int results_seen;

  int          beats_sent    = 0;
  int          settings_used = 0;
  int          burst_left    = 0;
  bit          steady_phase  = 1'b0;
  stall_mode_t stall_mode    = STALL_NONE;
  int          stall_left    = 0;

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  banked_memory_address_translator_core #(
    .RAM_BANKS(RAM_BANKS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bmat_translation_checker #(
    .RAM_BANKS(RAM_BANKS)
  ) checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .beats_taken  (beats_taken),
    .results_seen (results_seen)
  );

  // result side stall: a run of one mode, then another mode picked at random
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 96);
    end else begin
      stall_left = stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    out_stall <= ($urandom_range(0, 9) < 7);
      default:        out_stall <= ((stall_left % 5) < 2);
    endcase
  end

  function automatic in_beat_t mk_beat(input opcode_t op, input logic [15:0] addr,
                                       input logic [7:0] ext);
    in_beat_t b;
    b.opcode         = op;
    b.cpu_address    = addr;
    b.extension_byte = ext;
    return b;
  endfunction

  // address biased towards the decode boundaries
  function automatic logic [15:0] pick_address();
    logic [15:0] edges[14];
    edges = '{16'h0000, 16'h00FF, 16'h0100, 16'h1FFF, 16'h2000, 16'h9FFF, 16'hA000,
              16'hBFFF, 16'hC000, 16'hCFFF, 16'hD000, 16'hEFFF, 16'hF000, 16'hFFFF};
    case ($urandom_range(0, 9))
      0:       return 16'($urandom_range(0, 16'h00FF));
      1:       return 16'($urandom_range(VEC_LO, VEC_HI));
      2:       return edges[$urandom_range(0, 13)];
      default: return 16'($urandom);
    endcase
  endfunction

  // extension byte weighted towards the special codes
  function automatic logic [7:0] pick_extension();
    case ($urandom_range(0, 9))
      0, 1, 2: return EXT_SYS_WINDOW;
      3, 4:    return 8'($urandom_range(EXT_BANK_LO, EXT_BANK_HI));
      5, 6:    return EXT_CPU_MAP;
      7:       return 8'($urandom_range(8'h00, 8'h7F));
      8:       return 8'($urandom_range(8'h90, 8'hFE));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_beat(input in_beat_t beat);
    int goal;
    goal = beats_taken + 1;
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(negedge clk); while (beats_taken < goal);
    beats_sent++;
  endtask

  task automatic pause_cycles(input int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // sender holds off until every outstanding translation has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // registers only change with nothing in flight
  task automatic new_setting(input logic [7:0] zp, input logic [7:0] bank);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ZERO_PAGE;
    cfg_data  <= zp;
    @(negedge clk);
    cfg_index <= CFG_BANK;
    cfg_data  <= bank;
    @(negedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  // bursts of random length, gaps between them unless the phase runs flat out
  task automatic paced_send(input in_beat_t beat);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady_phase) pause_cycles($urandom_range(1, 8));
    end
    burst_left--;
    send_beat(beat);
  endtask

  initial begin
    int          sent_in_phase;
    int          run_len;
    logic [7:0]  zp;
    logic [7:0]  bank;
    logic [7:0]  zp_edges[7];
    zp_edges = '{8'h00, 8'hFF, 8'h17, 8'h1F, 8'h20, 8'h9F, 8'hA0};

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // system bank zero page, reset bank value rewritten, field extremes
    new_setting(8'h00, 8'hFF);
    send_beat(mk_beat(OP_ZERO_PAGE, 16'h0000, 8'h00));
    send_beat(mk_beat(OP_ZERO_PAGE, 16'hFFFF, 8'hFF));

    // zero page in the banked window, top bank requested so it folds
    new_setting(8'h50, 8'h07);
    send_beat(mk_beat(OP_ZERO_PAGE, 16'h0012, 8'h00));
    send_beat(mk_beat(OP_ZERO_PAGE, 16'h80AB, EXT_SYS_WINDOW));

    // zero page above the window; indexed access outside the extension pages
    new_setting(8'hFF, 8'h00);
    send_beat(mk_beat(OP_ZERO_PAGE, 16'h00FF, 8'h00));
    send_beat(mk_beat(OP_INDEXED, 16'h1234, EXT_SYS_WINDOW));

    // extension pages: every extension byte class and address range
    new_setting(EXT_PAGE_LO, 8'h83);
    send_beat(mk_beat(OP_ZERO_PAGE, 16'h0034, 8'h00));
    send_beat(mk_beat(OP_INDEXED, VEC_LO, EXT_SYS_WINDOW));
    send_beat(mk_beat(OP_INDEXED, VEC_HI, EXT_SYS_WINDOW));
    send_beat(mk_beat(OP_INDEXED, 16'h0000, EXT_SYS_WINDOW));
    send_beat(mk_beat(OP_INDEXED, 16'h1FFF, EXT_SYS_WINDOW));
    send_beat(mk_beat(OP_INDEXED, WINDOW_END, EXT_SYS_WINDOW));
    send_beat(mk_beat(OP_INDEXED, 16'h9FFF, EXT_SYS_WINDOW));
    send_beat(mk_beat(OP_INDEXED, 16'h0042, EXT_BANK_LO));
    send_beat(mk_beat(OP_INDEXED, 16'h3000, EXT_BANK_HI));
    send_beat(mk_beat(OP_INDEXED, 16'hFFFF, 8'h87));
    send_beat(mk_beat(OP_INDEXED, 16'h1000, EXT_CPU_MAP));
    send_beat(mk_beat(OP_INDEXED, 16'h4000, EXT_CPU_MAP));
    send_beat(mk_beat(OP_INDEXED, 16'hB000, EXT_CPU_MAP));
    send_beat(mk_beat(OP_INDEXED, 16'hC800, EXT_CPU_MAP));
    send_beat(mk_beat(OP_INDEXED, 16'hE000, EXT_CPU_MAP));
    send_beat(mk_beat(OP_INDEXED, 16'hF800, EXT_CPU_MAP));
    send_beat(mk_beat(OP_INDEXED, 16'h00FF, 8'h00));
    send_beat(mk_beat(OP_INDEXED, ZP_END, 8'h7F));

    // random phases: mostly a zero page access followed by a few indexed
    // accesses that use it, with loose single accesses as noise
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == RANDOM_PHASES - 2) begin
        zp   = 8'hFF;
        bank = 8'h00;
      end else if (phase == RANDOM_PHASES - 1) begin
        zp   = EXT_PAGE_HI;
        bank = 8'hFF;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: zp = 8'($urandom_range(EXT_PAGE_LO, EXT_PAGE_HI));
          5:             zp = zp_edges[$urandom_range(0, 6)];
          default:       zp = 8'($urandom);
        endcase
        case ($urandom_range(0, 3))
          0:       bank = 8'hFF;
          1:       bank = 8'h00;
          default: bank = 8'($urandom);
        endcase
      end
      new_setting(zp, bank);
      steady_phase  = ((phase % 4) == 3);
      burst_left    = 0;
      sent_in_phase = 0;
      while (sent_in_phase < BEATS_PER_PHASE) begin
        if ($urandom_range(0, 4) == 0) begin
          paced_send(mk_beat(opcode_t'($urandom_range(0, 1)), 16'($urandom), 8'($urandom)));
          sent_in_phase++;
        end else begin
          paced_send(mk_beat(OP_ZERO_PAGE, pick_address(), 8'($urandom)));
          sent_in_phase++;
          run_len = $urandom_range(1, 4);
          for (int k = 0; k < run_len; k++) begin
            paced_send(mk_beat(OP_INDEXED, pick_address(), pick_extension()));
            sent_in_phase++;
          end
        end
      end
    end

    drain();
    repeat (2 * SETTLE_CYCLES) @(negedge clk);
    $display("%0d accesses driven under %0d register settings, corners then random runs",
             beats_sent, settings_used);
    $display("%0d translations compared, %0d mismatches", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

### filelist.f
rtl/bmat_pkg.sv
rtl/bmat_bank_map.sv
rtl/bmat_wrap_offset.sv
rtl/bmat_translate.sv
rtl/banked_memory_address_translator_core.sv
sim/bmat_translation_checker.sv
sim/banked_memory_address_translator_core_test.sv
